[sv/isr_pkg.sv]
// Package for the integer square root pipeline.
// Holds the stage payload type and the shared digit recurrence step.
// No dependencies; used by isr_stage and integer_square_root_top.
package isr_pkg;

  localparam int RAD_BITS    = 31;
  localparam int ROOT_BITS   = 16;
  localparam int WORK_BITS   = 2 * ROOT_BITS;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int STAGE_STEPS = 4;
  localparam int NUM_STAGES  = ROOT_BITS / STAGE_STEPS;

  typedef struct packed {
    logic [WORK_BITS-1:0] rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } data_t;

  // One root bit: bring down two radicand bits, try to subtract 4*root+1.
  function automatic data_t sqrt_step(input data_t d);
    data_t                res;
    logic [REM_BITS+1:0]  trial;
    logic [REM_BITS+1:0]  sub;
    logic [REM_BITS+1:0]  diff;
    res   = d;
    trial = {d.rem, d.rad[WORK_BITS-1 -: 2]};
    sub   = {2'b00, d.root, 2'b01};
    diff  = trial - sub;
    res.rad = {d.rad[WORK_BITS-3:0], 2'b00};
    if (trial >= sub) begin
      res.rem  = diff[REM_BITS-1:0];
      res.root = {d.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      res.rem  = trial[REM_BITS-1:0];
      res.root = {d.root[ROOT_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic data_t stage_steps(input data_t d);
    data_t res;
    res = d;
    for (int i = 0; i < STAGE_STEPS; i++) begin
      res = sqrt_step(res);
    end
    return res;
  endfunction

endpackage

[sv/integer_square_root_top.sv]
// Top level of the integer square root block: a chain of isr_stage instances.
// Depends on isr_pkg and isr_stage.
//
// Usage: a 31-bit unsigned radicand enters on in_radicand with in_valid and
// in_ready; a transfer happens on a rising edge where both are high. The
// floor square root leaves on out_root with out_valid and out_ready, one
// result per radicand, in order.
// The root is found one bit per recurrence step, four steps per stage, in
// four register stages; out_root is taken from the last stage's register.
// The block takes one radicand every cycle while the receiver keeps
// out_ready high.
// When the receiver stalls, results hold in their stages and the pipeline
// closes its bubbles; in_ready falls only when every stage is full.
// The synchronous active-low reset clears all valid bits, so the block is
// empty and ready after reset. No state survives between radicands.
module integer_square_root_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [isr_pkg::RAD_BITS-1:0]  in_radicand,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [isr_pkg::ROOT_BITS-1:0] out_root
);

  localparam int NS = isr_pkg::NUM_STAGES;

  logic           valid_s [NS+1];
  logic           ready_s [NS+1];
  isr_pkg::data_t data_s  [NS+1];

  assign data_s[0] = '{
    rad:  {{(isr_pkg::WORK_BITS - isr_pkg::RAD_BITS){1'b0}}, in_radicand},
    rem:  '0,
    root: '0
  };

  assign valid_s[0]  = in_valid;
  assign in_ready    = ready_s[0];
  assign ready_s[NS] = out_ready;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    isr_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_s[g]),
      .in_data   (data_s[g]),
      .in_ready  (ready_s[g]),
      .out_valid (valid_s[g+1]),
      .out_data  (data_s[g+1]),
      .out_ready (ready_s[g+1])
    );
  end

  assign out_valid = valid_s[NS];
  assign out_root  = data_s[NS].root;

endmodule

[sv/isr_stage.sv]
// One pipeline stage of the integer square root: four root bits per stage.
// Depends on isr_pkg for the payload type and the recurrence step.
module isr_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  isr_pkg::data_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  output isr_pkg::data_t out_data,
  input  logic           out_ready
);

  logic           valid_r;
  logic           valid_nxt;
  isr_pkg::data_t data_r;
  isr_pkg::data_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;
  assign data_nxt  = isr_pkg::stage_steps(in_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for integer_square_root_top: floor square roots of 31-bit radicands.
// A queue-fed driver and a checking monitor, both with random idle bursts.
// Depends on isr_pkg and the integer_square_root_top RTL.
module testbench;

  localparam int RAD_W = isr_pkg::RAD_BITS;
  localparam int ROOT_W = isr_pkg::ROOT_BITS;
  localparam longint RAD_MAX = (longint'(1) << RAD_W) - 1;
  localparam int TAIL_ITEMS = 64;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RAD_W-1:0] in_radicand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROOT_W-1:0] out_root;

  logic [RAD_W-1:0] pending_radicands[$];
  logic [ROOT_W-1:0] expected_roots[$];
  int fail_count = 0;
  int in_idle_left = 0;
  int in_idle_pct = 10;
  int out_stall_left = 0;
  int out_stall_pct = 10;

  integer_square_root_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_radicand(in_radicand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_root(out_root)
  );

  always #5 clk = ~clk;

  // Restoring method: keep each root bit, from the top, if the square of the trial root still fits.
  function automatic logic [ROOT_W-1:0] floor_square_root(input logic [RAD_W-1:0] radicand);
    logic [63:0] acc;
    logic [63:0] trial;
    acc = '0;
    for (int pos = ROOT_W - 1; pos >= 0; pos--) begin
      trial = acc | (64'd1 << pos);
      if (trial * trial <= 64'(radicand)) begin
        acc = trial;
      end
    end
    return acc[ROOT_W-1:0];
  endfunction

  task automatic add_radicand(input longint value);
    if (value < 0) begin
      value = 0;
    end
    if (value > RAD_MAX) begin
      value = RAD_MAX;
    end
    pending_radicands.push_back(value[RAD_W-1:0]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_radicand <= '0;
      in_idle_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_roots.push_back(floor_square_root(in_radicand));
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0: in_idle_pct = 0;
            1: in_idle_pct = 10;
            default: in_idle_pct = 35;
          endcase
        end
      end
      if (!in_valid || in_ready) begin
        if (in_idle_left > 0) begin
          in_idle_left--;
          in_valid <= 1'b0;
        end else if (pending_radicands.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_radicands.size() > TAIL_ITEMS &&
                     $urandom_range(0, 99) < in_idle_pct) begin
          in_idle_left = $urandom_range(1, 4) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_radicand <= pending_radicands.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected transfer: root %0d with no expected result", out_root);
          fail_count++;
        end else begin
          if (out_root !== expected_roots[0]) begin
            $error("root mismatch: expected %0d, actual %0d", expected_roots[0], out_root);
            fail_count++;
          end
          void'(expected_roots.pop_front());
        end
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0: out_stall_pct = 0;
            1: out_stall_pct = 10;
            default: out_stall_pct = 35;
          endcase
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else if (pending_radicands.size() > TAIL_ITEMS &&
                   $urandom_range(0, 99) < out_stall_pct) begin
        out_stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    longint k;
    longint value;
    int pick;

    add_radicand(0);
    add_radicand(1);
    add_radicand(2);
    add_radicand(3);
    add_radicand(4);
    add_radicand(8);
    add_radicand(9);
    add_radicand(15);
    add_radicand(16);
    add_radicand(17);
    add_radicand(65024);
    add_radicand(65025);
    add_radicand(longint'(1) << 30);
    add_radicand((longint'(1) << 30) - 1);
    add_radicand(46340 * 46340 - 1);
    add_radicand(46340 * 46340);
    add_radicand(46340 * 46340 + 1);
    add_radicand(RAD_MAX);
    add_radicand(RAD_MAX - 1);
    add_radicand(longint'(32'h5555_5555) & RAD_MAX);
    add_radicand(longint'(32'h2AAA_AAAA) & RAD_MAX);
    add_radicand(longint'(1) << 15);
    add_radicand((longint'(1) << 16) * (longint'(1) << 14) + 1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        value = longint'($urandom()) & RAD_MAX;
      end else if (pick < 70) begin
        k = $urandom_range(0, 46340);
        value = k * k;
        case ($urandom_range(0, 3))
          0: value = value - 1;
          1: value = value + 1;
          2: value = value + 2 * k;
          default: value = value;
        endcase
      end else if (pick < 85) begin
        value = $urandom_range(0, 1023);
      end else begin
        value = (longint'(1) << $urandom_range(0, RAD_W - 1)) - $urandom_range(0, 1);
      end
      add_radicand(value);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_radicands.size() != 0 || in_valid || expected_roots.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_roots.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
